/* rtl/rnpp_pkg.sv */
package rnpp_pkg;

	// point limit and derived widths
	localparam int unsigned MAX_POINTS = 1048576;
	localparam int CNT_W = 21;
	localparam int IDX_W = 20;
	localparam int ALONG_W = 31;

	// queue between front and back
	localparam int QDEPTH = 8;
	localparam int QPTR_W = 3;
	localparam int QCNT_W = 4;

	// register indexes (byte address is 4 times the index)
	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_START_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X   = 3'd3;
	localparam logic [2:0] REG_DIR_Y   = 3'd4;
	localparam logic [2:0] REG_DIR_Z   = 3'd5;
	localparam logic [2:0] REG_RADIUS  = 3'd6;

	// unit direction in signed q1.30
	typedef struct packed {
		logic               ok;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
	} dir_t;

	// one classified point handed from front to back
	typedef struct packed {
		logic               exam;
		logic               last;
		logic [IDX_W-1:0]   index;
		logic [63:0]        miss;
		logic [ALONG_W-1:0] along;
	} item_t;

endpackage

/* rtl/rnpp_norm.sv */
module rnpp_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        dir_x,
	input  logic [31:0]        dir_y,
	input  logic [31:0]        dir_z,
	output logic               busy,
	output rnpp_pkg::dir_t     dir
);

	typedef enum logic [2:0] {N_IDLE, N_LOAD, N_SHIFT, N_SQ, N_SQRT, N_DIV} state_t;

	state_t      state_q;
	logic [2:0]  sgn_q;
	logic [31:0] m_q [3];
	logic [1:0]  k_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [32:0] rem_q;
	logic [61:0] dq_q;
	logic [5:0]  cnt_q;

	logic [31:0] m_or;
	logic [63:0] sq_prod;
	logic [63:0] res_bit;
	logic [33:0] trial;
	logic        qbit;
	logic [33:0] rem_next;
	logic [61:0] dq_next;
	logic [31:0] qmag;
	logic [31:0] uval;

	assign busy = (state_q != N_IDLE);

	// shared datapath pieces
	assign m_or     = m_q[0] | m_q[1] | m_q[2];
	assign sq_prod  = 64'(m_q[k_q]) * 64'(m_q[k_q]);
	assign res_bit  = res_q + bit_q;
	assign trial    = {rem_q, dq_q[61]};
	assign qbit     = (trial >= {2'b00, res_q[31:0]});
	assign rem_next = qbit ? (trial - {2'b00, res_q[31:0]}) : trial;
	assign dq_next  = {dq_q[60:0], qbit};
	assign qmag     = {1'b0, dq_next[30:0]};
	assign uval     = sgn_q[k_q] ? (32'd0 - qmag) : qmag;

	// sequencer: shift up, sum of squares, square root, three divisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			dir     <= '0;
			sgn_q   <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			res_q   <= '0;
			bit_q   <= '0;
			rem_q   <= '0;
			dq_q    <= '0;
			m_q[0]  <= '0;
			m_q[1]  <= '0;
			m_q[2]  <= '0;
		end else if (start) begin
			state_q <= N_LOAD;
		end else begin
			case (state_q)
				N_IDLE: begin
					state_q <= N_IDLE;
				end
				N_LOAD: begin
					sgn_q   <= {dir_z[31], dir_y[31], dir_x[31]};
					m_q[0]  <= dir_x[31] ? (32'd0 - dir_x) : dir_x;
					m_q[1]  <= dir_y[31] ? (32'd0 - dir_y) : dir_y;
					m_q[2]  <= dir_z[31] ? (32'd0 - dir_z) : dir_z;
					state_q <= N_SHIFT;
				end
				N_SHIFT: begin
					if (m_or == 32'd0) begin
						dir     <= '0;
						state_q <= N_IDLE;
					end else if (m_or[31:30] == 2'b00) begin
						m_q[0] <= {m_q[0][30:0], 1'b0};
						m_q[1] <= {m_q[1][30:0], 1'b0};
						m_q[2] <= {m_q[2][30:0], 1'b0};
					end else begin
						k_q     <= 2'd0;
						acc_q   <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					acc_q <= acc_q + sq_prod;
					if (k_q == 2'd2) begin
						res_q   <= '0;
						bit_q   <= 64'd1 << 62;
						state_q <= N_SQRT;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				N_SQRT: begin
					if (acc_q >= res_bit) begin
						acc_q <= acc_q - res_bit;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 64'd1) begin
						k_q     <= 2'd0;
						cnt_q   <= '0;
						rem_q   <= '0;
						dq_q    <= {m_q[0], 30'd0};
						state_q <= N_DIV;
					end
				end
				N_DIV: begin
					if (cnt_q == 6'd61) begin
						case (k_q)
							2'd0:    dir.ux <= uval;
							2'd1:    dir.uy <= uval;
							default: dir.uz <= uval;
						endcase
						if (k_q == 2'd2) begin
							dir.ok  <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							k_q   <= k_q + 2'd1;
							cnt_q <= '0;
							rem_q <= '0;
							dq_q  <= {m_q[k_q + 2'd1], 30'd0};
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
						rem_q <= rem_next[32:0];
						dq_q  <= dq_next;
					end
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/rnpp_front.sv */
module rnpp_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [31:0]                         point_x,
	input  logic [31:0]                         point_y,
	input  logic [31:0]                         point_z,
	input  logic                                last_point,
	input  logic [31:0]                         start_x,
	input  logic [31:0]                         start_y,
	input  logic [31:0]                         start_z,
	input  rnpp_pkg::dir_t                      dir,
	input  logic                                norm_busy,
	input  logic [rnpp_pkg::QCNT_W-1:0]         q_count,
	output logic                                push,
	output rnpp_pkg::item_t                     push_item
);

	logic                         accept;
	logic [rnpp_pkg::QCNT_W-1:0]  inflight;
	logic [rnpp_pkg::CNT_W-1:0]   count_q;
	logic                         in_range;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ex_s1, ex_s2, ex_s3, ex_s4, ex_s5;
	logic ls_s1, ls_s2, ls_s3, ls_s4, ls_s5;
	logic [rnpp_pkg::IDX_W-1:0] ix_s1, ix_s2, ix_s3, ix_s4, ix_s5;

	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic [32:0]        ax, ay, az;
	logic signed [64:0] px_s2, py_s2, pz_s2;
	logic [64:0]        qx_s2, qy_s2, qz_s2;
	logic signed [66:0] traw_s3;
	logic [66:0]        vsq_s3, vsq_s4, vsq_s5;
	logic [33:0]        t_s4;
	logic [67:0]        tsq_s5;
	logic [rnpp_pkg::ALONG_W-1:0] along_s5;
	logic [67:0]        diff;
	logic [63:0]        miss;

	// credits: queue entries plus beats still in the pipeline
	assign inflight = q_count + rnpp_pkg::QCNT_W'(v_s1) + rnpp_pkg::QCNT_W'(v_s2)
		+ rnpp_pkg::QCNT_W'(v_s3) + rnpp_pkg::QCNT_W'(v_s4)
		+ rnpp_pkg::QCNT_W'(v_s5) + rnpp_pkg::QCNT_W'(v_s6);
	assign in_stall = norm_busy || (inflight >= rnpp_pkg::QCNT_W'(rnpp_pkg::QDEPTH));
	assign accept   = in_valid && !in_stall;
	assign in_range = (count_q < rnpp_pkg::CNT_W'(rnpp_pkg::MAX_POINTS));

	// point index, restarts after the last beat of a cloud
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (last_point) begin
				count_q <= '0;
			end else if (in_range) begin
				count_q <= count_q + rnpp_pkg::CNT_W'(1);
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// magnitudes of the offset
	assign ax = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign ay = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
	assign az = dz_s1[32] ? 33'(-dz_s1) : 33'(dz_s1);

	// miss = |v|^2 - t^2, clamped at zero and saturated at 64 bits
	assign diff = {1'b0, vsq_s5} - tsq_s5;
	assign miss = (tsq_s5 >= {1'b0, vsq_s5}) ? 64'd0 :
		((diff[67:64] != 4'd0) ? {64{1'b1}} : diff[63:0]);

	// datapath stages
	always_ff @(posedge clk) begin
		// s1: offset from ray start
		ex_s1 <= dir.ok && in_range;
		ls_s1 <= last_point;
		ix_s1 <= count_q[rnpp_pkg::IDX_W-1:0];
		dx_s1 <= {point_x[31], point_x} - {start_x[31], start_x};
		dy_s1 <= {point_y[31], point_y} - {start_y[31], start_y};
		dz_s1 <= {point_z[31], point_z} - {start_z[31], start_z};
		// s2: dot terms and squares
		ex_s2 <= ex_s1;
		ls_s2 <= ls_s1;
		ix_s2 <= ix_s1;
		px_s2 <= 65'(dx_s1) * 65'($signed(dir.ux));
		py_s2 <= 65'(dy_s1) * 65'($signed(dir.uy));
		pz_s2 <= 65'(dz_s1) * 65'($signed(dir.uz));
		qx_s2 <= 65'(ax) * 65'(ax);
		qy_s2 <= 65'(ay) * 65'(ay);
		qz_s2 <= 65'(az) * 65'(az);
		// s3: sums
		ex_s3   <= ex_s2;
		ls_s3   <= ls_s2;
		ix_s3   <= ix_s2;
		traw_s3 <= 67'(px_s2) + 67'(py_s2) + 67'(pz_s2);
		vsq_s3  <= 67'(qx_s2) + 67'(qy_s2) + 67'(qz_s2);
		// s4: projection, only strictly positive t counts
		ex_s4  <= ex_s3 && !traw_s3[66] && (traw_s3[63:30] != 34'd0);
		ls_s4  <= ls_s3;
		ix_s4  <= ix_s3;
		t_s4   <= traw_s3[63:30];
		vsq_s4 <= vsq_s3;
		// s5: t squared
		ex_s5    <= ex_s4;
		ls_s5    <= ls_s4;
		ix_s5    <= ix_s4;
		tsq_s5   <= 68'(t_s4) * 68'(t_s4);
		vsq_s5   <= vsq_s4;
		along_s5 <= (t_s4[33:31] != 3'd0) ? {rnpp_pkg::ALONG_W{1'b1}} : t_s4[30:0];
		// s6: miss, ready for the queue
		push_item.exam  <= ex_s5;
		push_item.last  <= ls_s5;
		push_item.index <= ix_s5;
		push_item.miss  <= miss;
		push_item.along <= along_s5;
	end

	assign push = v_s6;

endmodule

/* rtl/rnpp_fifo.sv */
module rnpp_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  rnpp_pkg::item_t               push_item,
	input  logic                          pop,
	output rnpp_pkg::item_t               pop_item,
	output logic                          not_empty,
	output logic [rnpp_pkg::QCNT_W-1:0]   count
);

	rnpp_pkg::item_t             slot_q [rnpp_pkg::QDEPTH];
	logic [rnpp_pkg::QPTR_W-1:0] wr_q;
	logic [rnpp_pkg::QPTR_W-1:0] rd_q;
	logic [rnpp_pkg::QCNT_W-1:0] cnt_q;

	assign pop_item  = slot_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + rnpp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + rnpp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + rnpp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - rnpp_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* rtl/rnpp_back.sv */
module rnpp_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  rnpp_pkg::item_t                q_item,
	output logic                           pop,
	input  logic                           dir_ok,
	input  logic [61:0]                    r2,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           found,
	output logic [rnpp_pkg::IDX_W-1:0]     hit_index,
	output logic [rnpp_pkg::ALONG_W-1:0]   hit_distance
);

	logic [63:0]                  best_q;
	logic                         hit_q;
	logic [rnpp_pkg::IDX_W-1:0]   idx_q;
	logic [rnpp_pkg::ALONG_W-1:0] along_q;

	logic                         better;
	logic                         new_hit;
	logic                         hit_n;
	logic [rnpp_pkg::IDX_W-1:0]   idx_n;
	logic [rnpp_pkg::ALONG_W-1:0] along_n;

	assign pop = q_valid && (!out_valid || !out_stall);

	// running minimum, first index wins a tie
	assign better  = q_item.exam && (q_item.miss < best_q);
	assign new_hit = better && (q_item.miss < 64'(r2));
	assign hit_n   = hit_q || new_hit;
	assign idx_n   = new_hit ? q_item.index : idx_q;
	assign along_n = new_hit ? q_item.along : along_q;

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= {64{1'b1}};
			hit_q   <= 1'b0;
			idx_q   <= '0;
			along_q <= '0;
		end else if (pop) begin
			if (q_item.last) begin
				best_q  <= {64{1'b1}};
				hit_q   <= 1'b0;
				idx_q   <= '0;
				along_q <= '0;
			end else begin
				if (better) begin
					best_q <= q_item.miss;
				end
				hit_q   <= hit_n;
				idx_q   <= idx_n;
				along_q <= along_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			found        <= 1'b0;
			hit_index    <= '0;
			hit_distance <= '0;
		end else if (pop && q_item.last) begin
			out_valid    <= 1'b1;
			found        <= hit_n && dir_ok;
			hit_index    <= (hit_n && dir_ok) ? idx_n : '0;
			hit_distance <= (hit_n && dir_ok) ? along_n : '0;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

endmodule

/* rtl/ray_nearest_point_pick.sv */
// Picks the point of a streamed cloud that lies nearest to a ray.
// Configuration: APB-style writes set the ray start, direction and contact
// radius (byte addresses 0x00..0x18). A direction write starts a
// normalization sequence (load, shift up, sum of squares, square root,
// three divisions); in_stall stays high meanwhile.
// Input: one point per beat on in_valid / in_stall with last_point marking
// the end of a cloud. Points are taken one per cycle while in_stall is low; the
// six-stage arithmetic pipeline feeds an eight-entry queue, and in_stall
// rises when queue plus pipeline hold eight beats.
// Output: one beat per cloud on out_valid / out_stall, once the last point
// has passed the pipeline, the queue and the result register.
// A stalled result holds in its register while the queue keeps filling.
// Reset clears the direction to zero (no hits reported), the configuration
// registers, the running search and the queue.
module ray_nearest_point_pick (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic        last_point,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [19:0] hit_index,
	output logic [30:0] hit_distance
);

	logic [31:0] start_x_q, start_y_q, start_z_q;
	logic [31:0] dir_x_q, dir_y_q, dir_z_q;
	logic [30:0] radius_q;
	logic [61:0] r2_q;

	logic                        wr;
	logic [2:0]                  idx;
	logic                        dir_wr;
	logic                        norm_busy;
	rnpp_pkg::dir_t              dir;
	logic                        push;
	rnpp_pkg::item_t             push_item;
	logic                        pop;
	rnpp_pkg::item_t             pop_item;
	logic                        q_valid;
	logic [rnpp_pkg::QCNT_W-1:0] q_count;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign dir_wr = wr && ((idx == rnpp_pkg::REG_DIR_X) || (idx == rnpp_pkg::REG_DIR_Y)
		|| (idx == rnpp_pkg::REG_DIR_Z));

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			start_z_q <= '0;
			dir_x_q   <= '0;
			dir_y_q   <= '0;
			dir_z_q   <= '0;
			radius_q  <= '0;
			r2_q      <= '0;
		end else begin
			r2_q <= 62'(radius_q) * 62'(radius_q);
			if (wr) begin
				case (idx)
					rnpp_pkg::REG_START_X: start_x_q <= pwdata;
					rnpp_pkg::REG_START_Y: start_y_q <= pwdata;
					rnpp_pkg::REG_START_Z: start_z_q <= pwdata;
					rnpp_pkg::REG_DIR_X:   dir_x_q   <= pwdata;
					rnpp_pkg::REG_DIR_Y:   dir_y_q   <= pwdata;
					rnpp_pkg::REG_DIR_Z:   dir_z_q   <= pwdata;
					rnpp_pkg::REG_RADIUS:  radius_q  <= pwdata[30:0];
					default: ;
				endcase
			end
		end
	end

	// register reads
	always_comb begin
		case (idx)
			rnpp_pkg::REG_START_X: prdata = start_x_q;
			rnpp_pkg::REG_START_Y: prdata = start_y_q;
			rnpp_pkg::REG_START_Z: prdata = start_z_q;
			rnpp_pkg::REG_DIR_X:   prdata = dir_x_q;
			rnpp_pkg::REG_DIR_Y:   prdata = dir_y_q;
			rnpp_pkg::REG_DIR_Z:   prdata = dir_z_q;
			rnpp_pkg::REG_RADIUS:  prdata = {1'b0, radius_q};
			default:               prdata = '0;
		endcase
	end

	rnpp_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dir_wr),
		.dir_x  (dir_x_q),
		.dir_y  (dir_y_q),
		.dir_z  (dir_z_q),
		.busy   (norm_busy),
		.dir    (dir)
	);

	rnpp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.last_point (last_point),
		.start_x    (start_x_q),
		.start_y    (start_y_q),
		.start_z    (start_z_q),
		.dir        (dir),
		.norm_busy  (norm_busy),
		.q_count    (q_count),
		.push       (push),
		.push_item  (push_item)
	);

	rnpp_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (q_valid),
		.count     (q_count)
	);

	rnpp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (pop_item),
		.pop          (pop),
		.dir_ok       (dir.ok),
		.r2           (r2_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.hit_index    (hit_index),
		.hit_distance (hit_distance)
	);

`ifndef SYNTHESIS
	a_no_accept_while_norm: assert property (@(posedge clk) disable iff (!arst_n)
		norm_busy |-> in_stall)
		else $error("point taken during direction normalization");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < rnpp_pkg::QCNT_W'(rnpp_pkg::QDEPTH)) || pop)
		else $error("queue overflow");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (hit_index == '0) && (hit_distance == '0))
		else $error("miss result carries nonzero fields");

	a_dir_write_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		dir_wr |=> in_stall)
		else $error("input open right after direction write");
`endif

endmodule

/* tb/sv/rnpp_checker.sv */
module rnpp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [31:0] point_z,
	input  logic        last_point,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        found,
	input  logic [19:0] hit_index,
	input  logic [30:0] hit_distance,
	output int          fail_count,
	output int          pending,
	output int          picks_seen,
	output int          hits_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        found;
		logic [19:0] index;
		logic [30:0] along;
	} pick_t;

	// ray configuration and derived unit direction
	logic signed [31:0] ray_start [3];
	logic signed [31:0] ray_dir [3];
	logic [30:0]        radius;
	logic signed [63:0] unit_vec [3];
	logic               dir_valid;

	// running search state
	logic [63:0] min_miss;
	logic [19:0] min_index;
	logic [30:0] min_along;
	logic        have_hit;
	logic [20:0] npoints;

	pick_t pick_q[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// scale the direction up, divide by its integer square-root length
	task automatic normalize_ray();
		logic [63:0] m [3];
		logic [63:0] mx, sq, len, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = ray_dir[i] < 0 ? 64'(-64'(ray_dir[i])) : 64'(ray_dir[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) begin
			dir_valid = 0;
			for (int i = 0; i < 3; i++) unit_vec[i] = 0;
			return;
		end
		while (mx < (64'd1 << 30)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
		end
		sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		len = int_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] << 30) / len;
			unit_vec[i] = ray_dir[i] < 0 ? -$signed(q) : $signed(q);
		end
		dir_valid = 1;
	endtask

	task automatic clear_search();
		min_miss = '1;
		min_index = 0;
		min_along = 0;
		have_hit = 0;
		npoints = 0;
	endtask

	// project one point onto the ray and update the minimum
	task automatic examine_point(input logic [31:0] p [3], input logic [19:0] idx);
		logic signed [63:0] v [3];
		logic signed [63:0] traw;
		logic [63:0] t, miss, r2, mag;
		logic [129:0] vsq, tsq;
		traw = 0;
		vsq = 0;
		for (int i = 0; i < 3; i++) begin
			v[i] = 64'($signed(p[i])) - 64'(ray_start[i]);
			traw += v[i] * unit_vec[i];
			mag = v[i] < 0 ? 64'(-v[i]) : 64'(v[i]);
			vsq += 130'(mag) * 130'(mag);
		end
		if (traw <= 0) return;
		t = 64'(traw) >> 30;
		if (t == 0) return;
		tsq = 130'(t) * 130'(t);
		if (tsq >= vsq) miss = 0;
		else if ((vsq - tsq) >> 64 != 0) miss = '1;
		else miss = 64'(vsq - tsq);
		if (miss < min_miss) begin
			min_miss = miss;
			r2 = 64'(radius) * 64'(radius);
			if (miss < r2) begin
				have_hit = 1;
				min_index = idx;
				min_along = t > 64'h7FFFFFFF ? 31'h7FFFFFFF : t[30:0];
			end
		end
	endtask

	pick_t got, want, exp_pick;
	logic [31:0] pt [3];

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ray_start[i] = 0;
				ray_dir[i] = 0;
			end
			radius = 0;
			normalize_ray();
			clear_search();
			pick_q.delete();
			fail_count = 0;
			pending = 0;
			picks_seen = 0;
			hits_seen = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					rnpp_pkg::REG_START_X: ray_start[0] = pwdata;
					rnpp_pkg::REG_START_Y: ray_start[1] = pwdata;
					rnpp_pkg::REG_START_Z: ray_start[2] = pwdata;
					rnpp_pkg::REG_DIR_X:   ray_dir[0] = pwdata;
					rnpp_pkg::REG_DIR_Y:   ray_dir[1] = pwdata;
					rnpp_pkg::REG_DIR_Z:   ray_dir[2] = pwdata;
					rnpp_pkg::REG_RADIUS:  radius = pwdata[30:0];
					default: ;
				endcase
				normalize_ray();
			end
			// point beat
			if (in_valid && !in_stall) begin
				pt[0] = point_x;
				pt[1] = point_y;
				pt[2] = point_z;
				if (npoints < 21'(rnpp_pkg::MAX_POINTS)) begin
					if (dir_valid) examine_point(pt, npoints[19:0]);
					npoints++;
				end
				if (last_point) begin
					if (have_hit && dir_valid) exp_pick = '{1'b1, min_index, min_along};
					else exp_pick = '{1'b0, 20'd0, 31'd0};
					pick_q = {pick_q, exp_pick};
					clear_search();
				end
			end
			// result beat
			if (out_valid && !out_stall) begin
				got = '{found, hit_index, hit_distance};
				picks_seen++;
				if (found) hits_seen++;
				if (pick_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat found=%0b index=%0d along=%0d",
							found, hit_index, hit_distance);
				end else begin
					want = pick_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp found=%0b idx=%0d t=%0d got found=%0b idx=%0d t=%0d",
								want.found, want.index, want.along, got.found, got.index, got.along);
					end
				end
			end
			pending = pick_q.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [31:0] point_x, point_y, point_z;
	logic        last_point;
	logic        out_valid, out_stall;
	logic        found;
	logic [19:0] hit_index;
	logic [30:0] hit_distance;
	int          fail_count, pending, picks_seen, hits_seen;

	int  send_idle_pct, recv_stall_pct;
	bit  long_hold;
	int  cycle_count;
	int  beats_sent;

	// ray setting kept for building points near the ray
	logic signed [31:0] cur_start [3];
	logic signed [31:0] cur_dir [3];

	ray_nearest_point_pick u_top (.*);

	rnpp_checker u_chk (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("timeout");
			$display("[ray_nearest_point_pick] ERROR");
			$finish;
		end
	end

	// receiver stall
	initial begin
		int hold;
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1;
				hold = 0;
				while (hold < 300) begin
					@(negedge clk);
					hold++;
				end
				long_hold = 0;
				out_stall <= 0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// wait for results to drain, then let the direction setup settle
	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_ray(input logic [31:0] sx, sy, sz, dx, dy, dz, input logic [30:0] r);
		drain();
		reg_write(rnpp_pkg::REG_START_X, sx);
		reg_write(rnpp_pkg::REG_START_Y, sy);
		reg_write(rnpp_pkg::REG_START_Z, sz);
		reg_write(rnpp_pkg::REG_DIR_X, dx);
		reg_write(rnpp_pkg::REG_DIR_Y, dy);
		reg_write(rnpp_pkg::REG_DIR_Z, dz);
		reg_write(rnpp_pkg::REG_RADIUS, {1'b0, r});
		cur_start = '{sx, sy, sz};
		cur_dir = '{dx, dy, dz};
		repeat (300) @(negedge clk);
	endtask

	// one point beat, with optional idle gap before it
	task automatic send_point(input logic [31:0] x, y, z, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		last_point <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		@(negedge clk);
	endtask

	// point near the ray: start + k*dir/2^16 plus small jitter
	task automatic send_near(input logic lst);
		logic signed [63:0] k;
		logic [31:0] c [3];
		k = $urandom_range(4096);
		for (int i = 0; i < 3; i++)
			c[i] = 32'(64'(cur_start[i]) + ((64'(cur_dir[i]) * k) >>> 16)
				+ 64'($signed($urandom_range(8191)) - 4096));
		send_point(c[0], c[1], c[2], lst);
	endtask

	task automatic random_cloud(input int n);
		for (int j = 0; j < n; j++) begin
			if ($urandom_range(9) < 8) send_near(j == n - 1);
			else send_point($urandom, $urandom, $urandom, j == n - 1);
		end
	endtask

	task automatic random_ray();
		logic [31:0] d [3];
		case ($urandom_range(5))
			0: d = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000};
			1: d = '{32'd1, 32'd0, 32'd0};
			2: d = '{32'd0, 32'd0, 32'd0};
			default: d = '{$urandom_range(65535) << $urandom_range(14),
				$urandom, $urandom_range(65535) << $urandom_range(14)};
		endcase
		set_ray($urandom_range(1 << 20) - (1 << 19), $urandom, $urandom_range(1 << 20),
			d[0], d[1], d[2],
			$urandom_range(3) == 0 ? 31'h7FFFFFFF : 31'($urandom_range(1 << 17)));
	endtask

	initial begin
		int phase;
		clk = 0;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; point_x = 0; point_y = 0; point_z = 0; last_point = 0;
		send_idle_pct = 0; recv_stall_pct = 0; long_hold = 0;
		cycle_count = 0; beats_sent = 0;
		cur_start = '{0, 0, 0};
		cur_dir = '{0, 0, 0};
		repeat (7) @(negedge clk);
		arst_n = 1;

		// zero direction from reset: never found
		send_point(32'h7FFFFFFF, 32'h80000000, 32'd5, 1'b1);
		// axis ray, radius one meter
		set_ray(0, 0, 0, 32'h00010000, 0, 0, 31'h00010000);
		send_point(32'h00020000, 32'h00000100, 0, 0);      // hit
		send_point(32'h00030000, 32'h00000100, 0, 0);      // equal miss, earlier wins
		send_point(32'hFFFF0000, 0, 0, 0);                 // behind start
		send_point(32'h00000001, 0, 0, 0);                 // t of one, zero miss
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b1); // huge miss
		send_point(32'h00050000, 32'h00020000, 0, 1'b1);   // outside radius
		// extreme start and direction, full radius, large t saturating
		set_ray(32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
		send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_point(0, 0, 0, 0);
		send_point(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 1'b1);
		set_ray(32'hFFFFFFFF, 0, 32'h7FFFFFFF, 32'h80000000, 0, 32'd1, 0);
		send_point(32'h80000000, 0, 32'h7FFFFFFF, 0);
		send_point(32'h00000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b1);

		// random phases with varying idle patterns
		for (phase = 0; phase < 16; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			random_ray();
			if (phase == 5) long_hold = 1;
			while (beats_sent < 90 * (phase + 1) + 20)
				random_cloud($urandom_range(3) == 0 ? 1 : $urandom_range(2, 12));
			if (phase == 9) drain();
		end

		drain();
		repeat (40) @(negedge clk);
		$display("sent %0d point beats, %0d picks checked (%0d hits)",
			beats_sent, picks_seen, hits_seen);
		if (fail_count == 0)
			$display("[ray_nearest_point_pick] OK");
		else
			$display("[ray_nearest_point_pick] ERROR");
		$finish;
	end

endmodule
